### sv/greedy_disjoint_pattern_sum_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef GREEDY_DISJOINT_PATTERN_SUM_UNIT_DEFINES_SVH
`define GREEDY_DISJOINT_PATTERN_SUM_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define GDPS_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define GDPS_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/gdps_pkg.sv
package gdps_pkg;

  localparam int VC_W      = 7;
  localparam int PC_W      = 11;
  localparam int SCORE_W   = 32;
  localparam int BOUND_W   = 38;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam logic [BOUND_W-1:0] BOUND_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_VARIABLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT  = 2'd1;

  localparam logic [VC_W-1:0] VC_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } gdps_state_t;

endpackage

### sv/gdps_ram.sv
module gdps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/gdps_walker.sv
module gdps_walker
  import gdps_pkg::*;
#(
  parameter int MW = 65,
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MW-1:0]      start_rem,
  input  logic [CW-1:0]      limit,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [MW-1:0]      rd_mask,
  input  logic [SCORE_W-1:0] rd_score,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BOUND_W-1:0] out_bound
);

  gdps_state_t        state_r, state_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [MW-1:0]      rem_r, rem_nxt;
  logic [BOUND_W-1:0] sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BOUND_W-1:0] out_bound_r, out_bound_nxt;

  logic               start_empty;
  logic               hit;
  logic [MW-1:0]      rem_upd;
  logic [BOUND_W:0]   sum_add;
  logic [BOUND_W-1:0] sum_upd;
  logic               fin;
  logic               out_load;

  assign start_empty = (limit == '0) || (start_rem == '0);

  // Entry ptr_r-1 is on the read port during a walk cycle.
  assign hit     = ((rd_mask & ~rem_r) == '0);
  assign rem_upd = hit ? (rem_r & ~rd_mask) : rem_r;
  assign sum_add = {1'b0, sum_r} + (BOUND_W+1)'(rd_score);
  assign sum_upd = !hit ? sum_r :
                   sum_add[BOUND_W] ? BOUND_MAX : sum_add[BOUND_W-1:0];
  assign fin     = (ptr_r == limit) || (rem_upd == '0);

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = start_empty ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (fin) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    busy    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy  = 1'b0;
        rd_en = start && !start_empty;
      end
      ST_WALK: begin
        rd_en   = !fin;
        rd_addr = ptr_r[AW-1:0];
      end
      ST_DONE: begin
        busy = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    ptr_nxt = ptr_r;
    rem_nxt = rem_r;
    sum_nxt = sum_r;
    if (state_r == ST_IDLE && start) begin
      ptr_nxt = CW'(1);
      rem_nxt = start_rem;
      sum_nxt = '0;
    end else if (state_r == ST_WALK) begin
      ptr_nxt = ptr_r + CW'(1);
      rem_nxt = rem_upd;
      sum_nxt = sum_upd;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bound_nxt = out_bound_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_bound_nxt = sum_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r       <= ptr_nxt;
    rem_r       <= rem_nxt;
    sum_r       <= sum_nxt;
    out_bound_r <= out_bound_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_bound = out_bound_r;

endmodule

### sv/greedy_disjoint_pattern_sum_unit.sv
// Greedy disjoint pattern sum. A load transaction (in_kind = 0) writes one table entry
// (mask and score); loads with an index at or above MAX_PATTERNS are dropped. A query
// transaction (in_kind = 1) starts from all variable_count variables minus in_removed_set
// and walks entries 0 .. min(pattern_count, MAX_PATTERNS)-1 in order, one entry per cycle
// out of a single table memory with a registered read. Each entry whose mask fits in
// the remaining set adds its score (8 fraction bits, saturating at 38 bits) and removes its
// variables; the walk stops as soon as nothing remains. The input stays stalled while a
// query walks and until its result is loaded into the output register, which waits while
// the previous result there is still stalled. The result sits in an output register so
// the next transaction can be taken while it waits.
// The table is not cleared at reset: every entry a query reaches must have been loaded.
module greedy_disjoint_pattern_sum_unit
  import gdps_pkg::*;
#(
  parameter int MAX_PATTERNS  = 1024,
  parameter int MAX_VARIABLES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [9:0]           in_entry_index,
  input  logic [63:0]          in_entry_mask,
  input  logic [SCORE_W-1:0]   in_entry_score,
  input  logic [63:0]          in_removed_set,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BOUND_W-1:0]   out_bound,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int AW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int CW = $clog2(MAX_PATTERNS + 1);
  // Top mask bit flags any pattern bit beyond the supported variables.
  localparam int MW = MAX_VARIABLES + 1;
  localparam logic [63:0] LOW_MASK =
    (MAX_VARIABLES >= 64) ? '1 : ((64'd1 << MAX_VARIABLES) - 64'd1);

  logic [VC_W-1:0] variable_count_r, variable_count_nxt;
  logic [PC_W-1:0] pattern_count_r, pattern_count_nxt;

  logic                      in_acc;
  logic                      load_we;
  logic                      query_go;
  logic                      busy;
  logic [MAX_VARIABLES-1:0]  var_mask;
  logic [MW-1:0]             start_rem;
  logic [CW-1:0]             limit;
  logic                      hi_any;
  logic [MW+SCORE_W-1:0]     wr_data;
  logic [MW+SCORE_W-1:0]     rd_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;

  assign cfg_ready = 1'b1;

  always_comb begin
    variable_count_nxt = variable_count_r;
    pattern_count_nxt  = pattern_count_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VARIABLE_COUNT: variable_count_nxt = cfg_data[VC_W-1:0];
        REG_PATTERN_COUNT:  pattern_count_nxt  = cfg_data[PC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variable_count_r <= VC_RESET;
      pattern_count_r  <= '0;
    end else begin
      variable_count_r <= variable_count_nxt;
      pattern_count_r  <= pattern_count_nxt;
    end
  end

  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;
  assign load_we  = in_acc && !in_kind && (32'(in_entry_index) < 32'(MAX_PATTERNS));
  assign query_go = in_acc && in_kind;

  always_comb begin
    for (int i = 0; i < MAX_VARIABLES; i++) begin
      var_mask[i] = (variable_count_r > VC_W'(i));
    end
  end

  assign start_rem = {1'b0, var_mask & ~in_removed_set[MAX_VARIABLES-1:0]};
  assign limit     = (32'(pattern_count_r) > 32'(MAX_PATTERNS)) ?
                     CW'(MAX_PATTERNS) : CW'(pattern_count_r);

  assign hi_any  = |(in_entry_mask & ~LOW_MASK);
  assign wr_data = {in_entry_score, hi_any, in_entry_mask[MAX_VARIABLES-1:0]};

  gdps_ram #(
    .WIDTH (MW + SCORE_W),
    .DEPTH (MAX_PATTERNS)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gdps_walker #(
    .MW (MW),
    .AW (AW),
    .CW (CW)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (query_go),
    .start_rem (start_rem),
    .limit     (limit),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_mask   (rd_data[MW-1:0]),
    .rd_score  (rd_data[MW+SCORE_W-1:MW]),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bound (out_bound)
  );

endmodule

### sv/gdps_checker.sv
`include "greedy_disjoint_pattern_sum_unit_defines.svh"

module gdps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [37:0] out_bound
);

  `GDPS_ASSERT_ALL(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

  `GDPS_ASSERT_RUN(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_bound), "stalled result changed")

  `GDPS_ASSERT_RUN(a_query_blocks, in_valid && !in_stall && in_kind |=> in_stall, "input not stalled during query")

  `GDPS_ASSERT_RUN(a_load_no_result, in_valid && !in_stall && !in_kind && !out_valid |=> !out_valid, "load produced a result")

  `GDPS_ASSERT_RUN(a_result_from_walk, $rose(out_valid) |-> $past(in_stall), "result without a query in flight")

endmodule

bind greedy_disjoint_pattern_sum_unit gdps_checker u_checker (.*);
